### hw/rtl/cfr_pkg.sv
// cfr_pkg: shared types and constants for the checksummed command frame receiver
// used by cfr_frame_collect and the top level; no dependencies
package cfr_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hFF;
    localparam logic [7:0] SYNC_SECOND = 8'hFE;

    // frame position codes: hunting, first sync byte seen, then frame byte index
    localparam logic [3:0] POS_HUNT        = 4'd0;
    localparam logic [3:0] POS_SYNC_SEEN   = 4'd1;
    localparam logic [3:0] POS_FIRST_DATA  = 4'd2;
    localparam logic [3:0] POS_LAST_SUMMED = 4'd11;
    localparam logic [3:0] POS_LAST        = 4'd15;

    localparam int PAYLOAD_DEPTH = 10;
    localparam int CHECK_LOW_BYTES = 3;

    // sum of both sync bytes, the running sum at the start of a frame
    localparam logic [11:0] SYNC_SUM = 12'h1FD;

    typedef struct packed {
        logic        done;
        logic        checksum_ok;
        logic [7:0]  emergency_stop;
        logic [7:0]  plasma_relay_bits;
        logic [15:0] plasma_level;
        logic [7:0]  helium_relay_bits;
        logic [15:0] helium_level;
        logic [7:0]  argon_relay_bits;
        logic [15:0] argon_level;
    } t_frame_result;

endpackage

### hw/rtl/cfr_frame_collect.sv
// cfr_frame_collect: sync hunt, byte collection, running sum and check compare
// depends on cfr_pkg
module cfr_frame_collect (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_beat,
    input  logic [7:0]             i_rx_byte,
    output cfr_pkg::t_frame_result o_result
);
    import cfr_pkg::*;

    logic [3:0]  r_pos;
    logic [3:0]  n_pos;
    logic [11:0] r_sum;
    logic [11:0] n_sum;
    logic [7:0]  r_payload [PAYLOAD_DEPTH];
    logic [7:0]  r_check [CHECK_LOW_BYTES];
    logic [3:0]  payload_idx;
    logic [1:0]  check_idx;
    logic        check_match;

    assign payload_idx = r_pos - POS_FIRST_DATA;
    assign check_idx   = r_pos[1:0];

    // the 32-bit check word only matches if nothing sits above the 12-bit sum
    assign check_match = ({i_rx_byte, r_check[2], r_check[1], r_check[0]}
                          == {20'd0, r_sum});

    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        o_result = '0;
        if (r_pos == POS_HUNT) begin
            if (i_rx_byte == SYNC_FIRST) begin
                n_pos = POS_SYNC_SEEN;
            end
        end else if (r_pos == POS_SYNC_SEEN) begin
            if (i_rx_byte == SYNC_SECOND) begin
                n_pos = POS_FIRST_DATA;
                n_sum = SYNC_SUM;
            end else if (i_rx_byte != SYNC_FIRST) begin
                n_pos = POS_HUNT;
            end
        end else if (r_pos <= POS_LAST_SUMMED) begin
            n_pos = r_pos + 4'd1;
            n_sum = r_sum + {4'd0, i_rx_byte};
        end else if (r_pos != POS_LAST) begin
            n_pos = r_pos + 4'd1;
        end else begin
            n_pos = POS_HUNT;
            n_sum = '0;
            o_result.done = 1'b1;
            if (check_match) begin
                o_result.checksum_ok       = 1'b1;
                o_result.emergency_stop    = r_payload[0];
                o_result.plasma_relay_bits = r_payload[1];
                o_result.plasma_level      = {r_payload[3], r_payload[2]};
                o_result.helium_relay_bits = r_payload[4];
                o_result.helium_level      = {r_payload[6], r_payload[5]};
                o_result.argon_relay_bits  = r_payload[7];
                o_result.argon_level       = {r_payload[9], r_payload[8]};
            end
        end
        if (!i_beat) begin
            o_result.done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
            r_sum <= '0;
        end else if (i_beat) begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    // payload and check bytes: no reset, written before any frame reads them
    always_ff @(posedge i_clk) begin
        if (i_beat && r_pos >= POS_FIRST_DATA && r_pos <= POS_LAST_SUMMED) begin
            r_payload[payload_idx] <= i_rx_byte;
        end
        if (i_beat && r_pos > POS_LAST_SUMMED && r_pos != POS_LAST) begin
            r_check[check_idx] <= i_rx_byte;
        end
    end

endmodule

### hw/rtl/checksummed_command_frame_receiver.sv
// checksummed_command_frame_receiver: top level, input handshake and result register
// depends on cfr_pkg and cfr_frame_collect
//
// usage
//   input channel: one received byte per beat on i_rx_byte, i_in_valid / o_in_ready
//   output channel: one result per complete 16-byte frame, o_out_valid / i_out_ready
//   the block hunts for the sync pair ff fe, collects 14 more bytes, sums bytes 0..11
//   and compares the sum with the little-endian check word in bytes 12..15
//   a failed frame still gives one result, with o_checksum_ok low and all fields zero
// latency and throughput
//   one byte is taken per cycle while o_in_ready is high; the result of the last
//   frame byte shows on the output register the cycle after that byte's beat
//   the frame state updates once per accepted byte, so the rate is one byte
//   per cycle, bounded only by the single-entry result register
// reset
//   synchronous, active low; clears the hunt position, running sum and output valid
// stall
//   while a result waits and i_out_ready is low, o_in_ready drops; a byte that
//   would not finish a frame could be taken, but the stall holds all input so the
//   result register never needs a second entry; the waiting result stays stable
module checksummed_command_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_checksum_ok,
    output logic [7:0]  o_emergency_stop,
    output logic [7:0]  o_plasma_relay_bits,
    output logic [15:0] o_plasma_level,
    output logic [7:0]  o_helium_relay_bits,
    output logic [15:0] o_helium_level,
    output logic [7:0]  o_argon_relay_bits,
    output logic [15:0] o_argon_level
);
    import cfr_pkg::*;

    t_frame_result frame_res;
    t_frame_result r_res;
    logic          r_out_valid;
    logic          in_beat;

    // accept while the result register is empty or being drained this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_beat    = i_in_valid && o_in_ready;

    cfr_frame_collect u_collect (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (in_beat),
        .i_rx_byte (i_rx_byte),
        .o_result  (frame_res)
    );

    // result register valid: set by a frame end, cleared when the result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (frame_res.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, loaded only at frame end
    always_ff @(posedge i_clk) begin
        if (frame_res.done) begin
            r_res <= frame_res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_checksum_ok       = r_res.checksum_ok;
    assign o_emergency_stop    = r_res.emergency_stop;
    assign o_plasma_relay_bits = r_res.plasma_relay_bits;
    assign o_plasma_level      = r_res.plasma_level;
    assign o_helium_relay_bits = r_res.helium_relay_bits;
    assign o_helium_level      = r_res.helium_level;
    assign o_argon_relay_bits  = r_res.argon_relay_bits;
    assign o_argon_level       = r_res.argon_level;

endmodule

### hw/rtl/cfr_checker.sv
// cfr_checker: port-level assertions for the frame receiver
// bound to checksummed_command_frame_receiver; no package dependency
module cfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_checksum_ok,
    input logic [7:0]  o_emergency_stop,
    input logic [7:0]  o_plasma_relay_bits,
    input logic [15:0] o_plasma_level,
    input logic [7:0]  o_helium_relay_bits,
    input logic [15:0] o_helium_level,
    input logic [7:0]  o_argon_relay_bits,
    input logic [15:0] o_argon_level
);

    // a waiting result stays valid, and its check flag, emergency stop, plasma and argon levels hold
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_checksum_ok)
        && $stable(o_emergency_stop) && $stable(o_plasma_level)
        && $stable(o_argon_level))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a failed frame carries all-zero fields
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_checksum_ok |-> o_emergency_stop == 8'd0
        && o_plasma_relay_bits == 8'd0 && o_plasma_level == 16'd0
        && o_helium_relay_bits == 8'd0 && o_helium_level == 16'd0
        && o_argon_relay_bits == 8'd0 && o_argon_level == 16'd0)
        else $error("failed frame with nonzero fields");

    // a new result only follows an accepted byte
    a_result_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready))
        else $error("result without an input beat");

    // input is held off only behind a stalled result
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a waiting result");

endmodule

bind checksummed_command_frame_receiver cfr_checker u_cfr_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_ready          (o_in_ready),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_checksum_ok       (o_checksum_ok),
    .o_emergency_stop    (o_emergency_stop),
    .o_plasma_relay_bits (o_plasma_relay_bits),
    .o_plasma_level      (o_plasma_level),
    .o_helium_relay_bits (o_helium_relay_bits),
    .o_helium_level      (o_helium_level),
    .o_argon_relay_bits  (o_argon_relay_bits),
    .o_argon_level       (o_argon_level)
);
